// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock, masked while reset is asserted.
`define PLSS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// Checked on every clock, reset included.
`define PLSS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("%m: check failed");

`else

`define PLSS_ASSERT(label, prop)
`define PLSS_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== hw/rtl/plss_pkg.sv =====
`timescale 1ns / 1ps

package plss_pkg;

  // Wide enough to index a store of up to 64 entries.
  localparam int CELL_IDX_W = 6;

  typedef enum logic [2:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_READ_OUT  = 3'd6,
    OP_NOP       = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_INS  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_ROT  = 2'd3
  } cell_cmd_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_cmd_t               cmd;
    logic [CELL_IDX_W-1:0]   k;     // slot of insert or delete
    logic [CELL_IDX_W-1:0]   tail;  // last occupied slot, for rotation
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/plss_cell.sv =====
`timescale 1ns / 1ps

module plss_cell import plss_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  cell_ctrl_t  ctrl,
  input  logic [31:0] ins_value,
  input  logic [31:0] prev_val,
  input  logic [31:0] next_val,
  input  logic [31:0] head_val,
  output logic [31:0] val_r
);

  localparam logic [CELL_IDX_W-1:0] MY_IDX = CELL_IDX_W'(IDX);

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CMD_INS: begin
        if (MY_IDX > ctrl.k) begin
          val_r <= prev_val;
        end else if (MY_IDX == ctrl.k) begin
          val_r <= ins_value;
        end
      end
      CMD_DEL: begin
        if (MY_IDX >= ctrl.k) begin
          val_r <= next_val;
        end
      end
      CMD_ROT: begin
        // head wraps around to the tail slot
        if (MY_IDX == ctrl.tail) begin
          val_r <= head_val;
        end else if (MY_IDX < ctrl.tail) begin
          val_r <= next_val;
        end
      end
      default: begin
        val_r <= val_r;
      end
    endcase
  end

endmodule

// ===== hw/rtl/positional_list_shift_store_unit.sv =====
`timescale 1ns / 1ps
// Ordered list of signed 32-bit values in a row of CAPACITY shift cells.
// Input stream in_*: one word per operation (insert first/last/at, delete
// first/last/at, read out). Output stream out_*: one word per operation,
// except read out, which gives one word per entry from head to tail with
// out_tlast on the final one (an empty list gives a single status word).
// Every output word carries the occupancy after the operation.
// The result word is registered and is valid in the cycle after the input
// is taken. Inserts and deletes shift, load or hold all cells in parallel.
// During a read out the chain rotates one place toward the head per word, so
// after N words, N being the entry count, it is back in its original order.
// No input is taken during a read out.
// A single output register sits between the sides; a new input is taken in
// the cycle the previous word leaves. If out_tready is low the word holds
// and in_tready drops until it is taken.
// Reset (rst_n low, synchronous) empties the list and clears out_tvalid;
// cell contents are not cleared and are never read before being written.
`include "assert_macros.svh"

module positional_list_shift_store_unit import plss_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // opcode[2:0], value[34:3], position[42:35]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status[1:0], element[33:2],
                                  // element_index[38:34], occupancy[43:39]
  output logic        out_tlast
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > 8 ? CW : 8) + 1;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t         state_r;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  rd_idx_r;
  logic           out_valid_r;
  status_t        out_status_r;
  logic [31:0]    out_element_r;
  logic [4:0]     out_index_r;
  logic [4:0]     out_occ_r;
  logic           out_last_r;

  logic [31:0]    cell_val [CAPACITY];
  cell_ctrl_t     ctrl;

  op_t            op;
  logic [31:0]    in_value;
  logic [7:0]     in_pos;
  logic           accept;
  logic           out_free;
  logic           out_load;
  logic           empty;
  logic           full;
  logic [CW-1:0]  cnt_m1;
  logic [CW-1:0]  cnt_p1;
  logic [CW-1:0]  rd_next;
  logic [7:0]     pos_m1;
  logic           ins_req;
  logic           del_req;
  logic           range_ok;
  logic [IW-1:0]  k_sel;
  logic           is_read;
  status_t        st;
  logic [CW-1:0]  count_nxt;
  cell_cmd_t      cmd;

  assign op       = op_t'(in_tdata[2:0]);
  assign in_value = in_tdata[34:3];
  assign in_pos   = in_tdata[42:35];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  // a new word enters the output register on accept, or per step of a read out
  assign out_load  = (state_r == S_IDLE) ? accept : out_free;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(CAPACITY));
  assign cnt_m1  = count_r - 1'b1;
  assign cnt_p1  = count_r + 1'b1;
  assign rd_next = rd_idx_r + 1'b1;
  assign pos_m1  = in_pos - 8'd1;

  always_comb begin
    ins_req   = 1'b0;
    del_req   = 1'b0;
    range_ok  = 1'b1;
    k_sel     = '0;
    is_read   = 1'b0;
    st        = ST_OK;
    count_nxt = count_r;
    cmd       = CMD_HOLD;

    case (op)
      OP_INS_FIRST: begin
        ins_req = 1'b1;
      end
      OP_INS_LAST: begin
        ins_req = 1'b1;
        k_sel   = count_r[IW-1:0];
      end
      OP_INS_AT: begin
        ins_req  = 1'b1;
        range_ok = (in_pos != 8'd0) && (CMPW'(in_pos) <= CMPW'(count_r) + 1'b1);
        k_sel    = pos_m1[IW-1:0];
      end
      OP_DEL_FIRST: begin
        del_req  = 1'b1;
        range_ok = !empty;
      end
      OP_DEL_LAST: begin
        del_req  = 1'b1;
        range_ok = !empty;
        k_sel    = cnt_m1[IW-1:0];
      end
      OP_DEL_AT: begin
        del_req  = 1'b1;
        range_ok = (in_pos != 8'd0) && (CMPW'(in_pos) <= CMPW'(count_r));
        k_sel    = pos_m1[IW-1:0];
      end
      OP_READ_OUT: begin
        is_read = 1'b1;
      end
      default: begin
        st = ST_OK;
      end
    endcase

    if (ins_req) begin
      if (!range_ok) begin
        st = ST_RANGE;
      end else if (full) begin
        st = ST_FULL;
      end else begin
        cmd       = CMD_INS;
        count_nxt = cnt_p1;
      end
    end
    if (del_req) begin
      if (!range_ok) begin
        st = ST_RANGE;
      end else begin
        cmd       = CMD_DEL;
        count_nxt = cnt_m1;
      end
    end
    if (is_read) begin
      if (empty) begin
        st = ST_RANGE;
      end else begin
        cmd = CMD_ROT;
      end
    end

    ctrl.k    = CELL_IDX_W'(k_sel);
    ctrl.tail = CELL_IDX_W'(cnt_m1[IW-1:0]);
    if (state_r == S_READ) begin
      ctrl.cmd = out_free ? CMD_ROT : CMD_HOLD;
    end else begin
      ctrl.cmd = accept ? cmd : CMD_HOLD;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    plss_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .ins_value(in_value),
      .prev_val (cell_val[(i == 0) ? 0 : i - 1]),
      .next_val (cell_val[(i == CAPACITY - 1) ? i : i + 1]),
      .head_val (cell_val[0]),
      .val_r    (cell_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            count_r      <= count_nxt;
            out_status_r <= st;
            out_occ_r    <= 5'(count_nxt);
            if (is_read && !empty) begin
              out_element_r <= cell_val[0];
              out_index_r   <= 5'd1;
              out_last_r    <= (count_r == CW'(1));
              rd_idx_r      <= CW'(1);
              if (count_r != CW'(1)) begin
                state_r <= S_READ;
              end
            end else begin
              out_element_r <= '0;
              out_index_r   <= '0;
              out_last_r    <= 1'b1;
            end
          end
        end
        S_READ: begin
          if (out_free) begin
            out_status_r  <= ST_OK;
            out_occ_r     <= 5'(count_r);
            out_element_r <= cell_val[0];
            out_index_r   <= 5'(rd_next);
            out_last_r    <= (rd_next == count_r);
            rd_idx_r      <= rd_next;
            if (rd_next == count_r) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'd0, out_occ_r, out_index_r, out_element_r, out_status_r};

  `PLSS_ASSERT(a_count_bound, count_r <= CW'(CAPACITY))
  `PLSS_ASSERT(a_read_count_stable, (state_r == S_READ) |=> $stable(count_r))
  `PLSS_ASSERT(a_read_idx_range, (state_r == S_READ) |-> (rd_idx_r < count_r))
  `PLSS_ASSERT_ALWAYS(a_reset_no_valid, !rst_n |=> !out_tvalid)

endmodule
